[design/beat_phase_sync_rate_loop_top_macros.svh]
// Assertion macros used by the beat-phase sync rate loop controller.
// Each macro takes the clock and active-low reset that disable the check.
`ifndef BEAT_PHASE_SYNC_RATE_LOOP_TOP_MACROS_SVH
`define BEAT_PHASE_SYNC_RATE_LOOP_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPS_ASSERT_SAME(lbl, clk, rst_n, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPS_ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

[design/bpsrl_pkg.sv]
// Shared types and constants of the beat-phase sync rate loop.
// Used by the divider, datapath, controller and top level; depends on nothing.
`default_nettype none
package bpsrl_pkg;

    // Fixed point format of all fractions.
    localparam int FRAC_BITS = 16;
    localparam logic [16:0] ONE_Q = 17'h10000;

    // Divider word widths: dividend bits shifted in and step counter.
    localparam int QUOT_W = 33;
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] RATE_STEPS  = 6'd33;
    localparam logic [STEP_W-1:0] PHASE_STEPS = 6'd18;

    // Loop mode codes.
    localparam logic [2:0] MODE_BYPASS = 3'd0;
    localparam logic [2:0] MODE_HOLD   = 3'd1;
    localparam logic [2:0] MODE_SYNC   = 3'd2;
    localparam logic [2:0] MODE_PROP   = 3'd3;
    localparam logic [2:0] MODE_WRECK  = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_ERROR_TH = 3'd0;
    localparam logic [2:0] REG_WRECK_TH = 3'd1;
    localparam logic [2:0] REG_ADJ_CAP  = 3'd2;
    localparam logic [2:0] REG_GAIN     = 3'd3;
    localparam logic [2:0] REG_SLEW_CAP = 3'd4;

    // Register reset values.
    localparam logic [15:0] RST_ERROR_TH = 16'd655;
    localparam logic [15:0] RST_WRECK_TH = 16'd13107;
    localparam logic [15:0] RST_ADJ_CAP  = 16'd3277;
    localparam logic [16:0] RST_GAIN     = 17'd45875;
    localparam logic [15:0] RST_SLEW_CAP = 16'd1311;

    typedef struct packed {
        logic [15:0] error_threshold;
        logic [15:0] wreck_threshold;
        logic [15:0] adjust_cap;
        logic [16:0] loop_gain;
        logic [15:0] slew_cap;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rate_go;
        logic phase_go;
        logic rate_cap;
        logic phase_cap;
        logic err_calc;
        logic gain_mul;
        logic adj_calc;
        logic mul_lo;
        logic mul_hi;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_busy;
    } t_stat;

endpackage
`default_nettype wire

[design/bpsrl_div.sv]
// Serial restoring divider, one quotient bit per cycle.
// Uses bpsrl_pkg for the quotient and step counter widths.
`default_nettype none
module bpsrl_div #(
    parameter int DW = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [DW-1:0]                i_init_rem,
    input  wire logic [bpsrl_pkg::QUOT_W-1:0] i_bits,
    input  wire logic [bpsrl_pkg::STEP_W-1:0] i_steps,
    input  wire logic [DW-1:0]                i_divisor,
    output logic                              o_busy,
    output logic [bpsrl_pkg::QUOT_W-1:0]      o_quot
);

    logic [DW-1:0]                r_rem;
    logic [DW-1:0]                r_div;
    logic [bpsrl_pkg::QUOT_W-1:0] r_bits;
    logic [bpsrl_pkg::QUOT_W-1:0] r_quot;
    logic [bpsrl_pkg::STEP_W-1:0] r_cnt;
    logic                         r_busy;
    logic [DW:0]                  w_trial;
    logic [DW:0]                  w_diff;
    logic                         w_ge;

    // Bring down the next dividend bit and try the subtraction.
    assign w_trial = {r_rem, r_bits[bpsrl_pkg::QUOT_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    // Step counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == bpsrl_pkg::STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Remainder, dividend and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_init_rem;
            r_div  <= i_divisor;
            r_bits <= i_bits;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_bits <= {r_bits[bpsrl_pkg::QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[bpsrl_pkg::QUOT_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

[design/bpsrl_datapath.sv]
// Datapath of the sync rate loop: captured word, loop state, divider,
// shared multiplier and the correction arithmetic. Uses bpsrl_pkg and bpsrl_div.
`default_nettype none
module bpsrl_datapath #(
    parameter int P_BITS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bpsrl_pkg::t_cmd   i_cmd,
    output bpsrl_pkg::t_stat       o_stat,
    input  wire bpsrl_pkg::t_cfg   i_cfg,
    input  wire logic [15:0]       i_target_phase,
    input  wire logic [16:0]       i_target_bpm,
    input  wire logic [16:0]       i_deck_bpm,
    input  wire logic signed [17:0] i_user_tweak,
    input  wire logic [P_BITS-1:0] i_play_position,
    input  wire logic [P_BITS-1:0] i_prev_beat,
    input  wire logic [P_BITS-1:0] i_next_beat,
    input  wire logic              i_beats_known,
    input  wire logic              i_lock_disabled,
    input  wire logic [P_BITS-1:0] i_loop_span,
    input  wire logic              i_restart,
    output logic [21:0]            o_sync_rate,
    output logic [16:0]            o_correction,
    output logic signed [17:0]     o_phase_error,
    output logic [2:0]             o_loop_mode
);

    localparam int DW = (P_BITS > 17) ? P_BITS : 17;
    localparam int QW = bpsrl_pkg::QUOT_W;

    // Captured input word.
    logic [15:0]        r_tphase;
    logic [16:0]        r_tbpm;
    logic [16:0]        r_lbpm;
    logic signed [17:0] r_tweak;
    logic [P_BITS-1:0]  r_pos;
    logic [P_BITS-1:0]  r_prev;
    logic [P_BITS-1:0]  r_next;
    logic               r_known;
    logic               r_lock_off;
    logic [P_BITS-1:0]  r_loop;

    // Loop state kept between ticks.
    logic [16:0]        r_last_corr;
    logic signed [17:0] r_user_off;
    logic               r_pending;

    // Intermediate results.
    logic [32:0]        r_rate;
    logic [16:0]        r_phase;
    logic signed [18:0] r_err;
    logic [17:0]        r_aerr;
    logic [2:0]         r_mode;
    logic [34:0]        r_prod;
    logic [16:0]        r_adj;
    logic [51:0]        r_acc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tphase   <= i_target_phase;
            r_tbpm     <= i_target_bpm;
            r_lbpm     <= i_deck_bpm;
            r_tweak    <= i_user_tweak;
            r_pos      <= i_play_position;
            r_prev     <= i_prev_beat;
            r_next     <= i_next_beat;
            r_known    <= i_beats_known;
            r_lock_off <= i_lock_disabled;
            r_loop     <= i_loop_span;
        end
    end

    // Bypass when locking is off, beats unknown, or a loop is shorter than a beat.
    logic [P_BITS-1:0] w_beat_len;
    logic              w_bypass;
    assign w_beat_len = r_next - r_prev;
    assign w_bypass   = r_lock_off || !r_known ||
                        ((r_loop != '0) && (r_next > r_prev) && (r_loop < w_beat_len));

    // Deck phase operands: signed distances and their magnitudes.
    logic signed [P_BITS:0] w_d;
    logic signed [P_BITS:0] w_len;
    logic [P_BITS:0]        w_dneg;
    logic [P_BITS:0]        w_lneg;
    logic [P_BITS-1:0]      w_ud;
    logic [P_BITS-1:0]      w_ul;
    logic                   w_neg;
    logic                   w_len_zero;
    logic                   w_over4;
    assign w_d        = $signed({1'b0, r_pos}) - $signed({1'b0, r_prev});
    assign w_len      = $signed({1'b0, r_next}) - $signed({1'b0, r_prev});
    assign w_dneg     = -w_d;
    assign w_lneg     = -w_len;
    assign w_ud       = w_d[P_BITS] ? w_dneg[P_BITS-1:0] : w_d[P_BITS-1:0];
    assign w_ul       = w_len[P_BITS] ? w_lneg[P_BITS-1:0] : w_len[P_BITS-1:0];
    assign w_neg      = w_d[P_BITS] != w_len[P_BITS];
    assign w_len_zero = (r_next == r_prev);
    assign w_over4    = {2'b00, w_ud} >= {w_ul, 2'b00};

    // Divider operand selection: tempo ratio or deck phase.
    logic [DW-1:0] w_div_init;
    logic [QW-1:0] w_div_bits;
    logic [bpsrl_pkg::STEP_W-1:0] w_div_steps;
    logic [DW-1:0] w_div_divisor;
    logic [QW-1:0] w_quot;
    logic          w_div_busy;

    always_comb begin
        if (i_cmd.phase_go) begin
            w_div_init    = DW'(w_ud >> 2);
            w_div_bits    = {w_ud[1:0], {(QW-2){1'b0}}};
            w_div_steps   = bpsrl_pkg::PHASE_STEPS;
            w_div_divisor = DW'(w_ul);
        end else begin
            w_div_init    = '0;
            w_div_bits    = {r_tbpm, {bpsrl_pkg::FRAC_BITS{1'b0}}};
            w_div_steps   = bpsrl_pkg::RATE_STEPS;
            w_div_divisor = DW'(r_lbpm);
        end
    end

    bpsrl_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.rate_go || i_cmd.phase_go),
        .i_init_rem (w_div_init),
        .i_bits     (w_div_bits),
        .i_steps    (w_div_steps),
        .i_divisor  (w_div_divisor),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    assign o_stat.div_busy = w_div_busy;

    // Wrap the deck phase into one beat.
    logic [18:0]        w_q;
    logic signed [20:0] w_f;
    logic [16:0]        w_phase;
    always_comb begin
        w_q = w_over4 ? 19'h40000 : {1'b0, w_quot[17:0]};
        w_f = w_neg ? -$signed({2'b00, w_q}) : $signed({2'b00, w_q});
        if (w_f < 0) begin
            w_f = w_f + 21'sd65536;
        end
        if (w_f > 21'sd65536) begin
            w_f = w_f - 21'sd65536;
        end
        if (w_f < 0) begin
            w_phase = '0;
        end else if (w_f > 21'sd65536) begin
            w_phase = bpsrl_pkg::ONE_Q;
        end else begin
            w_phase = w_f[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rate_cap) begin
            r_rate <= (r_lbpm == '0) ? 33'(bpsrl_pkg::ONE_Q) : w_quot;
        end
        if (i_cmd.phase_cap) begin
            r_phase <= w_len_zero ? '0 : w_phase;
        end
    end

    // Shortest wrapped distance from the master phase to the deck phase.
    logic signed [18:0] w_cur;
    logic signed [18:0] w_tgt;
    logic signed [18:0] w_fwd;
    logic signed [18:0] w_back;
    logic signed [18:0] w_afwd;
    logic signed [18:0] w_aback;
    logic signed [18:0] w_dist;
    logic signed [18:0] w_err;
    logic signed [18:0] w_eneg;
    logic [17:0]        w_aerr;
    always_comb begin
        w_cur = $signed({3'b000, r_tphase});
        w_tgt = $signed({2'b00, r_phase});
        if (w_cur < w_tgt) begin
            w_fwd  = w_tgt - w_cur;
            w_back = w_tgt - w_cur - 19'sd65536;
        end else begin
            w_fwd  = 19'sd65536 - w_cur + w_tgt;
            w_back = w_tgt - w_cur;
        end
        w_afwd  = (w_fwd < 0) ? -w_fwd : w_fwd;
        w_aback = (w_back < 0) ? -w_back : w_back;
        if (w_cur == w_tgt) begin
            w_dist = '0;
        end else begin
            w_dist = (w_afwd < w_aback) ? w_fwd : w_back;
        end
        w_err  = w_dist - 19'(r_user_off);
        w_eneg = -w_err;
        w_aerr = w_err[18] ? w_eneg[17:0] : w_err[17:0];
    end

    // Mode decision.
    logic [2:0] w_mode;
    always_comb begin
        if (w_bypass) begin
            w_mode = bpsrl_pkg::MODE_BYPASS;
        end else if (r_tweak != '0) begin
            w_mode = bpsrl_pkg::MODE_HOLD;
        end else if (w_aerr > {2'b00, i_cfg.wreck_threshold}) begin
            w_mode = bpsrl_pkg::MODE_WRECK;
        end else if (w_aerr > {2'b00, i_cfg.error_threshold}) begin
            w_mode = bpsrl_pkg::MODE_PROP;
        end else begin
            w_mode = bpsrl_pkg::MODE_SYNC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err_calc) begin
            r_mode <= w_mode;
            r_err  <= w_bypass ? '0 : w_err;
            r_aerr <= w_aerr;
        end
    end

    // Base rate: tempo ratio plus tweak, never below zero.
    logic signed [34:0] w_base_s;
    logic [33:0]        w_base;
    assign w_base_s = $signed({2'b00, r_rate}) + 35'(r_tweak);
    assign w_base   = w_base_s[34] ? '0 : w_base_s[33:0];

    // Shared multiplier: gain product, then the rate in two halves.
    logic [17:0] w_ma;
    logic [16:0] w_mb;
    logic [34:0] w_mp;
    always_comb begin
        if (i_cmd.gain_mul) begin
            w_ma = r_aerr;
            w_mb = i_cfg.loop_gain;
        end else if (i_cmd.mul_hi) begin
            w_ma = {1'b0, w_base[33:17]};
            w_mb = r_adj;
        end else begin
            w_ma = {1'b0, w_base[16:0]};
            w_mb = r_adj;
        end
    end
    assign w_mp = w_ma * w_mb;

    // Proportional target with slew and deviation caps.
    logic [35:0]        w_pr;
    logic signed [23:0] w_pm;
    logic signed [23:0] w_tgt_corr;
    logic signed [23:0] w_delta;
    logic signed [23:0] w_dev;
    logic signed [23:0] w_slew;
    logic signed [23:0] w_cap;
    logic signed [23:0] w_last;
    logic [16:0]        w_adj;
    always_comb begin
        w_pr       = {1'b0, r_prod} + 36'd32768;
        w_pm       = $signed({4'b0000, w_pr[35:16]});
        w_slew     = $signed({8'h00, i_cfg.slew_cap});
        w_cap      = $signed({8'h00, i_cfg.adjust_cap});
        w_last     = $signed({7'h00, r_last_corr});
        w_tgt_corr = 24'sd65536 - (r_err[18] ? -w_pm : w_pm);
        w_delta    = w_tgt_corr - w_last;
        if (w_delta > w_slew) begin
            w_delta = w_slew;
        end else if (w_delta < -w_slew) begin
            w_delta = -w_slew;
        end
        w_dev = w_last - 24'sd65536 + w_delta;
        if (w_dev > w_cap) begin
            w_dev = w_cap;
        end else if (w_dev < -w_cap) begin
            w_dev = -w_cap;
        end
        case (r_mode)
            bpsrl_pkg::MODE_WRECK: w_adj = bpsrl_pkg::ONE_Q + {1'b0, i_cfg.adjust_cap};
            bpsrl_pkg::MODE_PROP:  w_adj = 17'(24'sd65536 + w_dev);
            default:               w_adj = bpsrl_pkg::ONE_Q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.gain_mul) begin
            r_prod <= w_mp;
        end
        if (i_cmd.adj_calc) begin
            r_adj <= w_adj;
        end
        if (i_cmd.mul_lo) begin
            r_acc <= 52'(w_mp);
        end else if (i_cmd.mul_hi) begin
            r_acc <= r_acc + {w_mp, 17'b0};
        end
    end

    // Loop state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_corr <= bpsrl_pkg::ONE_Q;
            r_user_off  <= '0;
            r_pending   <= 1'b0;
        end else begin
            if (i_cmd.load && i_restart) begin
                r_user_off <= '0;
                r_pending  <= 1'b1;
            end
            if (i_cmd.err_calc) begin
                if (w_bypass) begin
                    r_pending <= 1'b1;
                end else begin
                    if (r_pending) begin
                        r_last_corr <= bpsrl_pkg::ONE_Q;
                    end
                    r_pending <= 1'b0;
                    if (r_tweak != '0) begin
                        r_user_off <= w_dist[17:0];
                    end
                end
            end
            if (i_cmd.adj_calc && (r_mode != bpsrl_pkg::MODE_BYPASS)) begin
                r_last_corr <= w_adj;
            end
        end
    end

    // Round and saturate the final rate.
    logic [52:0] w_sum;
    assign w_sum         = {1'b0, r_acc} + 53'd32768;
    assign o_sync_rate   = (w_sum[52:38] != '0) ? 22'h3FFFFF : w_sum[37:16];
    assign o_correction  = r_adj;
    assign o_phase_error = r_err[17:0];
    assign o_loop_mode   = r_mode;

endmodule
`default_nettype wire

[design/bpsrl_ctrl.sv]
// Controller of the sync rate loop: sequences one word through the datapath.
// Uses bpsrl_pkg and the assertion macros header.
`default_nettype none
`include "beat_phase_sync_rate_loop_top_macros.svh"
module bpsrl_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire bpsrl_pkg::t_stat i_stat,
    input  wire logic             i_out_free,
    output bpsrl_pkg::t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RATE_GO  = 4'd1;
    localparam logic [3:0] S_RATE_RUN = 4'd2;
    localparam logic [3:0] S_PH_GO    = 4'd3;
    localparam logic [3:0] S_PH_RUN   = 4'd4;
    localparam logic [3:0] S_PH_CAP   = 4'd5;
    localparam logic [3:0] S_ERR      = 4'd6;
    localparam logic [3:0] S_GAIN     = 4'd7;
    localparam logic [3:0] S_ADJ      = 4'd8;
    localparam logic [3:0] S_MUL_LO   = 4'd9;
    localparam logic [3:0] S_MUL_HI   = 4'd10;
    localparam logic [3:0] S_OUT      = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RATE_GO;
                end
            end
            S_RATE_GO: begin
                o_cmd.rate_go = 1'b1;
                n_state       = S_RATE_RUN;
            end
            S_RATE_RUN: begin
                if (!i_stat.div_busy) begin
                    n_state = S_PH_GO;
                end
            end
            S_PH_GO: begin
                o_cmd.rate_cap = 1'b1;
                o_cmd.phase_go = 1'b1;
                n_state        = S_PH_RUN;
            end
            S_PH_RUN: begin
                if (!i_stat.div_busy) begin
                    n_state = S_PH_CAP;
                end
            end
            S_PH_CAP: begin
                o_cmd.phase_cap = 1'b1;
                n_state         = S_ERR;
            end
            S_ERR: begin
                o_cmd.err_calc = 1'b1;
                n_state        = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.gain_mul = 1'b1;
                n_state        = S_ADJ;
            end
            S_ADJ: begin
                o_cmd.adj_calc = 1'b1;
                n_state        = S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // An accepted word always starts the tempo division.
    `BPS_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_valid && o_ready, r_state == S_RATE_GO, "accepted word did not start the division")
    // A result waiting for a full output stage stays put.
    `BPS_ASSERT_NEXT(a_out_waits, i_clk, i_rst_n, r_state == S_OUT && !i_out_free, r_state == S_OUT, "result left before the output stage was free")
    // The phase division is running right after it was launched.
    `BPS_ASSERT_SAME(a_phase_busy, i_clk, i_rst_n, r_state == S_PH_RUN && $past(r_state) == S_PH_GO, i_stat.div_busy, "phase division not running after launch")

endmodule
`default_nettype wire

[design/beat_phase_sync_rate_loop_top.sv]
// One word is processed at a time: a new word is accepted only after the previous result
// has been loaded into the output register. The pace is set by the shared serial divider
// (33 steps for the tempo ratio, 18 for the deck phase) and the two-part rate multiply.
// A new word is taken while the previous result still waits in the output register.
// Synchronous active-low reset restores register defaults, correction 1.0,
// zero user offset and no pending history clear.
`default_nettype none
module beat_phase_sync_rate_loop_top #(
    parameter int POSITION_BITS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Fields from bit 0: target_phase, target_bpm, deck_bpm, user_tweak, play_position,
    // prev_beat, next_beat, beats_known, lock_disabled, loop_span, restart, zero pad.
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [((71 + 4 * POSITION_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // Fields from bit 0: sync_rate, correction, phase_error, loop_mode, zero pad.
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [63:0]              m_axis_tdata,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [4:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int P        = POSITION_BITS;
    localparam int OFF_POS  = 68;
    localparam int OFF_PREV = OFF_POS + P;
    localparam int OFF_NEXT = OFF_PREV + P;
    localparam int OFF_KNWN = OFF_NEXT + P;
    localparam int OFF_LOCK = OFF_KNWN + 1;
    localparam int OFF_LOOP = OFF_LOCK + 1;
    localparam int OFF_RST  = OFF_LOOP + P;

    // Configuration registers.
    bpsrl_pkg::t_cfg r_cfg;
    logic            w_cfg_wr;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.error_threshold <= bpsrl_pkg::RST_ERROR_TH;
            r_cfg.wreck_threshold <= bpsrl_pkg::RST_WRECK_TH;
            r_cfg.adjust_cap      <= bpsrl_pkg::RST_ADJ_CAP;
            r_cfg.loop_gain       <= bpsrl_pkg::RST_GAIN;
            r_cfg.slew_cap        <= bpsrl_pkg::RST_SLEW_CAP;
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                bpsrl_pkg::REG_ERROR_TH: r_cfg.error_threshold <= pwdata[15:0];
                bpsrl_pkg::REG_WRECK_TH: r_cfg.wreck_threshold <= pwdata[15:0];
                bpsrl_pkg::REG_ADJ_CAP:  r_cfg.adjust_cap      <= pwdata[15:0];
                bpsrl_pkg::REG_GAIN:     r_cfg.loop_gain       <= pwdata[16:0];
                bpsrl_pkg::REG_SLEW_CAP: r_cfg.slew_cap        <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[4:2])
            bpsrl_pkg::REG_ERROR_TH: prdata = {16'h0, r_cfg.error_threshold};
            bpsrl_pkg::REG_WRECK_TH: prdata = {16'h0, r_cfg.wreck_threshold};
            bpsrl_pkg::REG_ADJ_CAP:  prdata = {16'h0, r_cfg.adjust_cap};
            bpsrl_pkg::REG_GAIN:     prdata = {15'h0, r_cfg.loop_gain};
            bpsrl_pkg::REG_SLEW_CAP: prdata = {16'h0, r_cfg.slew_cap};
            default:                 prdata = '0;
        endcase
    end

    bpsrl_pkg::t_cmd  w_cmd;
    bpsrl_pkg::t_stat w_stat;
    logic             r_out_valid;
    logic             w_out_free;
    logic [21:0]      w_rate;
    logic [16:0]      w_corr;
    logic signed [17:0] w_perr;
    logic [2:0]       w_mode;

    assign w_out_free = !r_out_valid || m_axis_tready;

    bpsrl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_stat     (w_stat),
        .i_out_free (w_out_free),
        .o_cmd      (w_cmd)
    );

    bpsrl_datapath #(
        .P_BITS (P)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg           (r_cfg),
        .i_target_phase  (s_axis_tdata[15:0]),
        .i_target_bpm    (s_axis_tdata[32:16]),
        .i_deck_bpm      (s_axis_tdata[49:33]),
        .i_user_tweak    (s_axis_tdata[67:50]),
        .i_play_position (s_axis_tdata[OFF_POS +: P]),
        .i_prev_beat     (s_axis_tdata[OFF_PREV +: P]),
        .i_next_beat     (s_axis_tdata[OFF_NEXT +: P]),
        .i_beats_known   (s_axis_tdata[OFF_KNWN]),
        .i_lock_disabled (s_axis_tdata[OFF_LOCK]),
        .i_loop_span     (s_axis_tdata[OFF_LOOP +: P]),
        .i_restart       (s_axis_tdata[OFF_RST]),
        .o_sync_rate     (w_rate),
        .o_correction    (w_corr),
        .o_phase_error   (w_perr),
        .o_loop_mode     (w_mode)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            m_axis_tdata <= {4'h0, w_mode, w_perr, w_corr, w_rate};
        end
    end

    assign m_axis_tvalid = r_out_valid;

endmodule
`default_nettype wire

[verif/beat_phase_sync_rate_loop_checker.sv]
// Checker for the beat-phase sync rate loop: watches the input, output and APB channels,
// predicts each result word from its own model of the loop and compares field by field.
// Depends on bpsrl_pkg for register indexes, mode codes and register reset values.
`timescale 1ns / 100ps
module beat_phase_sync_rate_loop_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [199:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [63:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           o_fail_count,
    output int           o_waiting
);

    localparam longint UNIT = 64'd65536;
    localparam longint RATE_TOP = 64'd4194303;

    typedef struct {
        logic [21:0] sync_rate;
        logic [16:0] correction;
        logic [17:0] phase_error;
        logic [2:0]  loop_mode;
    } t_rate_word;

    // Shadow copy of the registers and of the loop state.
    longint err_th, wreck_th, adj_cap, gain, slew;
    longint prev_corr, offset;
    bit     clear_due;

    t_rate_word pending_rates[$];
    int         mismatches;

    assign o_fail_count = mismatches;
    assign o_waiting    = pending_rates.size();

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Phase of the play position between the surrounding beats, wrapped into [0, 1.0].
    function automatic longint deck_frac(longint pos, longint prv, longint nxt);
        longint d, len, ud, ul, q, f;
        d   = pos - prv;
        len = nxt - prv;
        if (len == 0) begin
            return 0;
        end
        ud = mag(d);
        ul = mag(len);
        if (ud >= 4 * ul) begin
            q = 4 * UNIT;
        end else begin
            q = (ud << 16) / ul;
        end
        f = ((d < 0) != (len < 0)) ? -q : q;
        if (f < 0) begin
            f += UNIT;
        end
        if (f > UNIT) begin
            f -= UNIT;
        end
        return clip(f, 0, UNIT);
    endfunction

    // Shortest signed distance from the master phase to the deck phase; ties go backward.
    function automatic longint nearest_step(longint cur, longint tgt);
        longint fwd, back;
        if (cur == tgt) begin
            return 0;
        end
        if (cur < tgt) begin
            fwd  = tgt - cur;
            back = tgt - cur - UNIT;
        end else begin
            fwd  = UNIT - cur + tgt;
            back = tgt - cur;
        end
        return mag(fwd) < mag(back) ? fwd : back;
    endfunction

    // Works out one result word and advances the shadow loop state.
    function automatic t_rate_word predict_rate(logic [199:0] w);
        t_rate_word r;
        longint tphase, tbpm, lbpm, tweak, pos, prv, nxt, loop_len;
        longint rate, base, adj, err, mine, near_dist, tgt, delta, prod, g;
        logic [2:0] mode;
        tphase   = w[15:0];
        tbpm     = w[32:16];
        lbpm     = w[49:33];
        tweak    = longint'($signed(w[67:50]));
        pos      = w[99:68];
        prv      = w[131:100];
        nxt      = w[163:132];
        loop_len = w[197:166];
        adj  = UNIT;
        err  = 0;
        mode = bpsrl_pkg::MODE_BYPASS;
        if (w[198]) begin
            offset    = 0;
            clear_due = 1'b1;
        end
        rate = (lbpm != 0) ? (tbpm << 16) / lbpm : UNIT;
        base = rate + tweak;
        if (base < 0) begin
            base = 0;
        end
        if (w[165] || !w[164] || (loop_len != 0 && nxt > prv && loop_len < nxt - prv)) begin
            clear_due = 1'b1;
        end else begin
            mine = deck_frac(pos, prv, nxt);
            if (clear_due) begin
                clear_due = 1'b0;
                prev_corr = UNIT;
            end
            near_dist = nearest_step(tphase, mine);
            err  = near_dist - offset;
            if (tweak != 0) begin
                mode   = bpsrl_pkg::MODE_HOLD;
                offset = near_dist;
            end else if (mag(err) > wreck_th) begin
                mode = bpsrl_pkg::MODE_WRECK;
                adj  = UNIT + adj_cap;
            end else if (mag(err) > err_th) begin
                g     = (mag(err) * gain + UNIT / 2) >> 16;
                tgt   = UNIT - (err < 0 ? -g : g);
                delta = clip(tgt - prev_corr, -slew, slew);
                mode  = bpsrl_pkg::MODE_PROP;
                adj   = UNIT + clip(prev_corr - UNIT + delta, -adj_cap, adj_cap);
            end else begin
                mode = bpsrl_pkg::MODE_SYNC;
            end
            prev_corr = adj;
        end
        prod = (base * adj + UNIT / 2) >> 16;
        if (prod > RATE_TOP) begin
            prod = RATE_TOP;
        end
        r.sync_rate   = prod[21:0];
        r.correction  = adj[16:0];
        r.phase_error = err[17:0];
        r.loop_mode   = mode;
        return r;
    endfunction

    // All three channels are sampled at the rising edge.
    always @(posedge i_clk) begin
        t_rate_word exp_w;
        if (!i_rst_n) begin
            err_th    = bpsrl_pkg::RST_ERROR_TH;
            wreck_th  = bpsrl_pkg::RST_WRECK_TH;
            adj_cap   = bpsrl_pkg::RST_ADJ_CAP;
            gain      = bpsrl_pkg::RST_GAIN;
            slew      = bpsrl_pkg::RST_SLEW_CAP;
            prev_corr = UNIT;
            offset    = 0;
            clear_due = 1'b0;
            pending_rates.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    bpsrl_pkg::REG_ERROR_TH: err_th   = pwdata[15:0];
                    bpsrl_pkg::REG_WRECK_TH: wreck_th = pwdata[15:0];
                    bpsrl_pkg::REG_ADJ_CAP:  adj_cap  = pwdata[15:0];
                    bpsrl_pkg::REG_GAIN:     gain     = pwdata[16:0];
                    bpsrl_pkg::REG_SLEW_CAP: slew     = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pending_rates.push_back(predict_rate(s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_rates.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Unexpected result word %h", m_axis_tdata);
                    end
                end else begin
                    exp_w = pending_rates.pop_front();
                    if (m_axis_tdata[21:0] !== exp_w.sync_rate
                            || m_axis_tdata[38:22] !== exp_w.correction
                            || m_axis_tdata[56:39] !== exp_w.phase_error
                            || m_axis_tdata[59:57] !== exp_w.loop_mode) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Mismatch rate/corr/err/mode: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                exp_w.sync_rate, exp_w.correction,
                                $signed(exp_w.phase_error), exp_w.loop_mode,
                                m_axis_tdata[21:0], m_axis_tdata[38:22],
                                $signed(m_axis_tdata[56:39]), m_axis_tdata[59:57]);
                        end
                    end
                end
            end
        end
    end

endmodule

[verif/tb_beat_phase_sync_rate_loop_top.sv]
// Testbench top for the beat-phase sync rate loop: clock, reset, APB set-up,
// directed and random tick words, output back-pressure and the verdict.
// Depends on bpsrl_pkg, beat_phase_sync_rate_loop_top and beat_phase_sync_rate_loop_checker.
`timescale 1ns / 100ps
module tb_beat_phase_sync_rate_loop_top;

    localparam int CYCLE_LIMIT = 3000000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    int fail_count;
    int waiting;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;

    always #6 i_clk = ~i_clk;

    beat_phase_sync_rate_loop_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    beat_phase_sync_rate_loop_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_fail_count(fail_count), .o_waiting(waiting)
    );

    // Output back-pressure follows the current stall percentage.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL beat_phase_sync_rate_loop_top");
            $finish;
        end
    end

    // One APB write: setup cycle, then access cycle.
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic write_all(logic [15:0] eth, logic [15:0] wth, logic [15:0] cap,
                             logic [16:0] g, logic [15:0] sc);
        write_reg(bpsrl_pkg::REG_ERROR_TH, 32'(eth));
        write_reg(bpsrl_pkg::REG_WRECK_TH, 32'(wth));
        write_reg(bpsrl_pkg::REG_ADJ_CAP, 32'(cap));
        write_reg(bpsrl_pkg::REG_GAIN, 32'(g));
        write_reg(bpsrl_pkg::REG_SLEW_CAP, 32'(sc));
    endtask

    // Holds off until every result is back, then lets the datapath drain.
    task automatic drain;
        while (waiting != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // Offers one tick word and waits for it to be taken.
    task automatic send_tick(logic [15:0] tph, logic [16:0] tbpm, logic [16:0] lbpm,
                             logic [17:0] tweak, logic [31:0] pos, logic [31:0] prv,
                             logic [31:0] nxt, logic known, logic off,
                             logic [31:0] loop_len, logic rst_flag);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {1'b0, rst_flag, loop_len, off, known, nxt, prv, pos, tweak,
                         lbpm, tbpm, tph};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic idle_input;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Random tick: mostly a sane follower deck, sometimes raw noise.
    task automatic random_tick;
        logic [31:0] prv, len, pos;
        logic [17:0] tweak;
        int sel;
        sel = $urandom_range(99);
        if (sel < 12) begin
            send_tick(16'($urandom), 17'($urandom), 17'($urandom), 18'($urandom),
                      $urandom, $urandom, $urandom, 1'($urandom), 1'($urandom),
                      $urandom, 1'($urandom));
        end else begin
            prv = $urandom;
            len = ($urandom_range(3) == 0) ? $urandom : $urandom_range(200000, 1);
            pos = prv + $urandom_range(len + len / 4) - len / 8;
            tweak = ($urandom_range(9) == 0) ? 18'($urandom_range(131072) - 65536) : 18'd0;
            send_tick(16'($urandom), 17'($urandom_range(131071)),
                      17'($urandom_range(131071, 1)), tweak,
                      pos, prv, prv + len, 1'b1, ($urandom_range(19) == 0),
                      ($urandom_range(7) == 0) ? $urandom_range(2 * len) : 32'd0,
                      ($urandom_range(24) == 0));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed ticks under the reset register values.
        send_tick(16'd0, 17'd30720, 17'd30720, 18'd0, 32'd500, 32'd0, 32'd1000,
                  1'b1, 1'b0, 32'd0, 1'b0);
        send_tick(16'hffff, 17'h1ffff, 17'd1, 18'd0, 32'd0, 32'd0, 32'd1000,
                  1'b1, 1'b0, 32'd0, 1'b0);
        send_tick(16'd100, 17'd0, 17'd0, 18'd0, 32'd10, 32'd10, 32'd10,
                  1'b1, 1'b0, 32'd0, 1'b0);
        send_tick(16'd0, 17'd30720, 17'd30000, 18'h10000, 32'd250, 32'd0, 32'd1000,
                  1'b1, 1'b0, 32'd0, 1'b0);
        send_tick(16'd0, 17'd30720, 17'd30000, 18'h30000, 32'd300, 32'd0, 32'd1000,
                  1'b1, 1'b0, 32'd0, 1'b0);
        send_tick(16'd0, 17'd30720, 17'd30000, 18'd0, 32'd300, 32'd0, 32'd1000,
                  1'b1, 1'b0, 32'd0, 1'b1);
        send_tick(16'd0, 17'd30720, 17'd30000, 18'd0, 32'd500, 32'd0, 32'd1000,
                  1'b1, 1'b0, 32'd0, 1'b0);
        send_tick(16'd32768, 17'd30720, 17'd30000, 18'd0, 32'd0, 32'd0, 32'd1000,
                  1'b1, 1'b0, 32'd0, 1'b0);
        send_tick(16'd0, 17'd30720, 17'd30000, 18'd0, 32'd20, 32'd0, 32'd1000,
                  1'b1, 1'b0, 32'd0, 1'b0);
        send_tick(16'd0, 17'd30720, 17'd30000, 18'd0, 32'd60, 32'd0, 32'd1000,
                  1'b1, 1'b0, 32'd0, 1'b0);
        send_tick(16'd4000, 17'd30720, 17'd30000, 18'd0, 32'd9000, 32'd0, 32'd1000,
                  1'b1, 1'b0, 32'd0, 1'b0);
        send_tick(16'd4000, 17'd30720, 17'd30000, 18'd0, 32'd1500, 32'd2000, 32'd1000,
                  1'b1, 1'b0, 32'd0, 1'b0);
        send_tick(16'd4000, 17'd30720, 17'd30000, 18'd0, 32'hffffffff, 32'd0, 32'd1000,
                  1'b1, 1'b0, 32'd0, 1'b0);
        send_tick(16'd9000, 17'd30720, 17'd30000, 18'd0, 32'd300, 32'd0, 32'd1000,
                  1'b0, 1'b0, 32'd0, 1'b0);
        send_tick(16'd9000, 17'd30720, 17'd30000, 18'd0, 32'd300, 32'd0, 32'd1000,
                  1'b1, 1'b1, 32'd0, 1'b0);
        send_tick(16'd9000, 17'd30720, 17'd30000, 18'd0, 32'd300, 32'd0, 32'd1000,
                  1'b1, 1'b0, 32'd999, 1'b0);
        send_tick(16'd9000, 17'd30720, 17'd30000, 18'd0, 32'd300, 32'd0, 32'd1000,
                  1'b1, 1'b0, 32'd1000, 1'b0);
        send_tick(16'd9000, 17'd30720, 17'd30000, 18'h20000, 32'd300, 32'd0, 32'd1000,
                  1'b1, 1'b0, 32'hffffffff, 1'b0);
        send_tick(16'd0, 17'h1ffff, 17'd1, 18'h10000, 32'd300, 32'd0, 32'd1000,
                  1'b1, 1'b0, 32'd0, 1'b0);
        send_tick(16'd0, 17'd30720, 17'd30000, 18'd0, 32'd300, 32'd0, 32'd1000,
                  1'b1, 1'b0, 32'd0, 1'b0);
        idle_input();
        drain();

        // Five random phases under different settings and idling patterns.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_all(16'd0, 16'd0, 16'd0, 17'd0, 16'd0);
                1: write_all(16'hffff, 16'hffff, 16'hffff, 17'h1ffff, 16'hffff);
                2: write_all(16'd300, 16'd20000, 16'd8000, 17'd90000, 16'd500);
                3: write_all(16'($urandom), 16'($urandom), 16'($urandom),
                             17'($urandom), 16'($urandom));
                default: write_all(bpsrl_pkg::RST_ERROR_TH, bpsrl_pkg::RST_WRECK_TH,
                                   bpsrl_pkg::RST_ADJ_CAP, bpsrl_pkg::RST_GAIN,
                                   bpsrl_pkg::RST_SLEW_CAP);
            endcase
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 66 : 16) : 0;
            recv_stall_pct = (ph == 2) ? 66 : ((ph == 3) ? 16 : 0);
            repeat (300) random_tick();
            idle_input();
            drain();
        end

        if (fail_count == 0) begin
            $display("PASS beat_phase_sync_rate_loop_top");
        end else begin
            $display("FAIL beat_phase_sync_rate_loop_top");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/bpsrl_pkg.sv
design/bpsrl_div.sv
design/bpsrl_datapath.sv
design/bpsrl_ctrl.sv
design/beat_phase_sync_rate_loop_top.sv
verif/beat_phase_sync_rate_loop_checker.sv
verif/tb_beat_phase_sync_rate_loop_top.sv
